>>> sv/ggcd_pkg.sv
// ----------------------------------------------------------------------------
// ggcd_pkg - gimbal and gripper command dispatch definitions
// Command codes, register indexes, gripper frame constants and helpers.
// ----------------------------------------------------------------------------
package ggcd_pkg;

	localparam int CmdWidth      = 8;
	localparam int MaxPulses     = 64;
	localparam int PulseCntWidth = $clog2(MaxPulses + 1);
	localparam int PulseIdxWidth = $clog2(MaxPulses);
	localparam int FrameLen      = 11;
	localparam int FrameIdxWidth = $clog2(FrameLen);
	localparam int CfgIdxWidth   = 3;
	localparam int CfgDataWidth  = 16;

	// command bytes
	localparam logic [CmdWidth-1:0] CMD_LEFT  = 8'h4C; // L
	localparam logic [CmdWidth-1:0] CMD_RIGHT = 8'h52; // R
	localparam logic [CmdWidth-1:0] CMD_UP    = 8'h55; // U
	localparam logic [CmdWidth-1:0] CMD_DOWN  = 8'h44; // D
	localparam logic [CmdWidth-1:0] CMD_OPEN  = 8'h4F; // O
	localparam logic [CmdWidth-1:0] CMD_CLOSE = 8'h43; // C

	// register indexes
	localparam logic [CfgIdxWidth-1:0] REG_PULSES      = 3'd0;
	localparam logic [CfgIdxWidth-1:0] REG_LOWER_REV   = 3'd1;
	localparam logic [CfgIdxWidth-1:0] REG_UPPER_REV   = 3'd2;
	localparam logic [CfgIdxWidth-1:0] REG_GRIP_ADDR   = 3'd3;
	localparam logic [CfgIdxWidth-1:0] REG_GRIP_SPEED  = 3'd4;
	localparam logic [CfgIdxWidth-1:0] REG_GRIP_CURR   = 3'd5;

	// register reset values
	localparam logic [6:0]  PULSES_RST     = 7'd18;
	localparam logic [7:0]  GRIP_ADDR_RST  = 8'd1;
	localparam logic [15:0] GRIP_SPEED_RST = 16'd1800;
	localparam logic [15:0] GRIP_CURR_RST  = 16'd2000;

	// frame constants
	localparam logic [7:0] FRAME_FUNC = 8'hC6;
	localparam logic [7:0] FRAME_FILL = 8'hFF;
	localparam logic [7:0] FRAME_ZERO = 8'h00;
	localparam logic [7:0] FRAME_END  = 8'h6B;

	localparam logic RESULT_PULSE  = 1'b0;
	localparam logic RESULT_SERIAL = 1'b1;

	typedef enum logic [1:0] {
		GRIP_UNKNOWN = 2'd0,
		GRIP_OPEN    = 2'd1,
		GRIP_CLOSED  = 2'd2
	} grip_pos_t;

	function automatic logic [7:0] frame_byte(
		input logic [FrameIdxWidth-1:0] idx,
		input logic [7:0]               addr,
		input logic                     open,
		input logic [15:0]              speed,
		input logic [15:0]              current
	);
		logic [7:0] b;
		case (idx)
			4'd0:    b = addr;
			4'd1:    b = FRAME_FUNC;
			4'd2:    b = {7'd0, open};
			4'd3:    b = FRAME_FILL;
			4'd4:    b = FRAME_FILL;
			4'd5:    b = speed[15:8];
			4'd6:    b = speed[7:0];
			4'd7:    b = FRAME_ZERO;
			4'd8:    b = current[15:8];
			4'd9:    b = current[7:0];
			4'd10:   b = FRAME_END;
			default: b = FRAME_ZERO;
		endcase
		return b;
	endfunction

endpackage

>>> sv/gimbal_gripper_command_dispatch.sv
// ----------------------------------------------------------------------------
// gimbal_gripper_command_dispatch - command byte to pulse / frame dispatcher
// Decodes one ASCII command per input word and emits step pulses or the
// gripper serial frame as a run of output words.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  s_*       in   tdata[7:0] command_byte
//  m_*       out  tdata[0] step_direction, tdata[8:1] serial_byte,
//                 tuser[0] result_kind, tuser[1] axis_select, tlast last_of_run
//  cfg_*     in   cfg_index selects register 0..5, cfg_data low bits written
//
// One output word per cycle unless the output stalls. A move emits
// pulses_per_move words (at most 64), a gripper command 11; the command
// register holds the run while a counter walks through it. The next command
// is taken in the cycle that loads the last word of a run, so runs follow
// back to back. Output stalls hold the output register and the counter.
// Reset restores the register defaults and clears the gripper record.
// ----------------------------------------------------------------------------
module gimbal_gripper_command_dispatch (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command word
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [ggcd_pkg::CmdWidth-1:0]        s_tdata,   // [7:0] command_byte
	// result word
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [15:0]                          m_tdata,   // [0] step_direction, [8:1] serial_byte
	output logic [1:0]                           m_tuser,   // [0] result_kind, [1] axis_select
	output logic                                 m_tlast,
	// configuration
	input  logic                                 cfg_we,
	input  logic [ggcd_pkg::CfgIdxWidth-1:0]     cfg_index,
	input  logic [ggcd_pkg::CfgDataWidth-1:0]    cfg_data
);
	import ggcd_pkg::*;

	// configuration registers
	logic [6:0]  pulses_q;
	logic        lower_rev_q;
	logic        upper_rev_q;
	logic [7:0]  grip_addr_q;
	logic [15:0] grip_speed_q;
	logic [15:0] grip_curr_q;
	grip_pos_t   grip_pos_q;

	// command register
	logic                     valid_s1;
	logic                     kind_s1;
	logic                     axis_s1;
	logic                     dir_s1;
	logic [PulseCntWidth-1:0] count_s1;
	logic [PulseIdxWidth-1:0] idx_s1;

	// output register
	logic        m_tvalid_q;
	logic        kind_q;
	logic        axis_q;
	logic        dir_q;
	logic [7:0]  byte_q;
	logic        last_q;

	logic                     out_free;
	logic                     emit;
	logic                     is_last;
	logic                     finish;
	logic                     accept;
	logic [PulseCntWidth-1:0] move_count;
	logic                     dec_valid;
	logic                     dec_kind;
	logic                     dec_axis;
	logic                     dec_dir;
	logic [PulseCntWidth-1:0] dec_count;
	logic                     dec_grip;
	grip_pos_t                dec_pos;
	logic [7:0]               emit_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_q     <= PULSES_RST;
			lower_rev_q  <= 1'b0;
			upper_rev_q  <= 1'b0;
			grip_addr_q  <= GRIP_ADDR_RST;
			grip_speed_q <= GRIP_SPEED_RST;
			grip_curr_q  <= GRIP_CURR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PULSES:     pulses_q     <= cfg_data[6:0];
				REG_LOWER_REV:  lower_rev_q  <= cfg_data[0];
				REG_UPPER_REV:  upper_rev_q  <= cfg_data[0];
				REG_GRIP_ADDR:  grip_addr_q  <= cfg_data[7:0];
				REG_GRIP_SPEED: grip_speed_q <= cfg_data;
				REG_GRIP_CURR:  grip_curr_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate the pulse count
	assign move_count = (pulses_q > 7'(MaxPulses)) ? PulseCntWidth'(MaxPulses)
		: PulseCntWidth'(pulses_q);

	always_comb begin
		dec_valid = 1'b0;
		dec_kind  = RESULT_PULSE;
		dec_axis  = 1'b0;
		dec_dir   = 1'b0;
		dec_count = move_count;
		dec_grip  = 1'b0;
		dec_pos   = grip_pos_q;
		case (s_tdata)
			CMD_LEFT: begin
				dec_valid = (move_count != '0);
				dec_dir   = lower_rev_q;
			end
			CMD_RIGHT: begin
				dec_valid = (move_count != '0);
				dec_dir   = ~lower_rev_q;
			end
			CMD_UP: begin
				dec_valid = (move_count != '0);
				dec_axis  = 1'b1;
				dec_dir   = upper_rev_q;
			end
			CMD_DOWN: begin
				dec_valid = (move_count != '0);
				dec_axis  = 1'b1;
				dec_dir   = ~upper_rev_q;
			end
			CMD_OPEN: begin
				dec_kind  = RESULT_SERIAL;
				dec_count = PulseCntWidth'(FrameLen);
				dec_dir   = 1'b1;
				dec_valid = (grip_pos_q != GRIP_OPEN);
				dec_grip  = dec_valid;
				dec_pos   = GRIP_OPEN;
			end
			CMD_CLOSE: begin
				dec_kind  = RESULT_SERIAL;
				dec_count = PulseCntWidth'(FrameLen);
				dec_valid = (grip_pos_q != GRIP_CLOSED);
				dec_grip  = dec_valid;
				dec_pos   = GRIP_CLOSED;
			end
			default: ;
		endcase
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign emit     = valid_s1 && out_free;
	assign is_last  = ({1'b0, idx_s1} + 1'b1) == count_s1;
	assign finish   = emit && is_last;
	assign s_tready = !valid_s1 || finish;
	assign accept   = s_tvalid && s_tready;

	// for a frame, dir_s1 carries the open flag
	assign emit_byte = frame_byte(idx_s1[FrameIdxWidth-1:0], grip_addr_q, dir_s1,
		grip_speed_q, grip_curr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			idx_s1     <= '0;
			grip_pos_q <= GRIP_UNKNOWN;
		end else begin
			if (accept) begin
				valid_s1 <= dec_valid;
				idx_s1   <= '0;
				if (dec_grip) begin
					grip_pos_q <= dec_pos;
				end
			end else if (finish) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				idx_s1 <= idx_s1 + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= dec_kind;
			axis_s1  <= dec_axis;
			dir_s1   <= dec_dir;
			count_s1 <= dec_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= kind_s1;
			last_q <= is_last;
			if (kind_s1 == RESULT_SERIAL) begin
				axis_q <= 1'b0;
				dir_q  <= 1'b0;
				byte_q <= emit_byte;
			end else begin
				axis_q <= axis_s1;
				dir_q  <= dir_s1;
				byte_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, byte_q, dir_q};
	assign m_tuser  = {axis_q, kind_q};
	assign m_tlast  = last_q;

	// a run in progress blocks new commands
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !finish |-> !s_tready)
		else $error("command taken while a run is in progress");

	// counter stays inside the run
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ({1'b0, idx_s1} < count_s1))
		else $error("run index beyond its count");

	// a frame ends with the end marker
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tlast |-> m_tdata[8:1] == FRAME_END)
		else $error("gripper frame ends with a wrong byte");

	// the gripper record moves only when a frame is started
	a_grip_change: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(grip_pos_q))
		else $error("gripper record changed without a command");

	// a loaded frame word never carries axis or direction
	a_serial_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tdata[0])
		else $error("serial word carries pulse fields");

endmodule
